// File: rtl/core/llgmd_pkg.sv
// Shared types and constants for the magnetization derivative unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package llgmd_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RATIO    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECESSION_ON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RATE    = 2'd2;

    // Configuration register file.
    typedef struct packed {
        logic [30:0] gyro_ratio;
        logic        precession_on;
        logic [30:0] relax_rate;
    } cfg_t;

    // Pipeline control shared by every stage of the datapath.
    typedef struct packed {
        logic en;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/llgmd_delay.sv
// Delay line that keeps side values aligned with the datapath stages.
// Depends on llgmd_pkg for the pipeline control struct.
`default_nettype none

module llgmd_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire                     aclk,
    input  llgmd_pkg::pipe_ctrl_t   ctrl,
    input  wire [WIDTH-1:0]         d,
    output logic [WIDTH-1:0]        q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // Shift along by one stage whenever the pipeline advances.
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// File: rtl/core/llgmd_qmul.sv
// Two-stage fixed-point multiplier with round half away from zero and saturation.
// Depends on llgmd_pkg for the pipeline control struct.
`default_nettype none

module llgmd_qmul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire                     aclk,
    input  llgmd_pkg::pipe_ctrl_t   ctrl,
    input  wire signed [W-1:0]      a,
    input  wire signed [W-1:0]      b,
    output logic signed [W-1:0]     p,
    output logic                    sat
);

    localparam logic [2*W:0] HALF  = (2*W+1)'(1) << (F-1);
    localparam logic [2*W:0] LIM_N = (2*W+1)'(1) << (W-1);
    localparam logic [2*W:0] LIM_P = LIM_N - (2*W+1)'(1);

    logic [W-1:0]     ua;
    logic [W-1:0]     ub;
    logic [2*W-1:0]   prod_reg;
    logic             neg_reg;
    logic [2*W:0]     rnd;
    logic [2*W:0]     shifted;
    logic [2*W:0]     limit;
    logic [W-1:0]     mag;
    logic             clip;
    logic signed [W-1:0] p_reg;
    logic             sat_reg;

    // Magnitudes of the operands; the most negative value maps onto 2^(W-1).
    assign ua = a[W-1] ? (W'(0) - a) : a;
    assign ub = b[W-1] ? (W'(0) - b) : b;

    // First stage: exact unsigned product and its sign.
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            prod_reg <= (2*W)'(ua) * (2*W)'(ub);
            neg_reg  <= a[W-1] ^ b[W-1];
        end
    end

    // Rounding on the magnitude, then clipping against the signed limit.
    always_comb begin
        rnd     = {1'b0, prod_reg} + HALF;
        shifted = rnd >> F;
        limit   = neg_reg ? LIM_N : LIM_P;
        clip    = shifted > limit;
        mag     = clip ? limit[W-1:0] : shifted[W-1:0];
    end

    // Second stage: signed result and clip flag.
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            p_reg   <= neg_reg ? (W'(0) - mag) : mag;
            sat_reg <= clip;
        end
    end

    assign p   = p_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// File: rtl/core/llgmd_div.sv
// Pipelined restoring divider forming -(g * 2^F / d), one quotient bit a stage.
// Depends on llgmd_pkg for the pipeline control struct.
`default_nettype none

module llgmd_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire                     aclk,
    input  llgmd_pkg::pipe_ctrl_t   ctrl,
    input  wire [W-2:0]             g,
    input  wire [W-2:0]             d,
    output logic signed [W-1:0]     q,
    output logic                    sat
);

    localparam int NB = W - 1 + F;
    localparam logic [NB-1:0] LIM = NB'(1) << (W-1);

    logic [W-2:0]  r_reg [NB];
    logic [NB-1:0] n_reg [NB];
    logic [NB-1:0] q_reg [NB];
    logic [W-2:0]  d_reg [NB];
    logic signed [W-1:0] q_out_reg;
    logic          sat_reg;
    logic          clip;
    logic [W-1:0]  mag;

    // One stage per numerator bit, from the most significant bit down.
    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [W-2:0]  r_in;
        logic [NB-1:0] n_in;
        logic [NB-1:0] q_in;
        logic [W-2:0]  d_in;
        logic [W-1:0]  trial;
        logic [W-1:0]  diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign n_in = {g, {F{1'b0}}};
            assign q_in = '0;
            assign d_in = d;
        end else begin : g_next
            assign r_in = r_reg[k-1];
            assign n_in = n_reg[k-1];
            assign q_in = q_reg[k-1];
            assign d_in = d_reg[k-1];
        end

        // Bring down the next bit and subtract the divisor where it fits.
        assign trial = {r_in, n_in[NB-1]};
        assign ge    = trial >= {1'b0, d_in};
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (ctrl.en) begin
                r_reg[k] <= ge ? diff[W-2:0] : trial[W-2:0];
                n_reg[k] <= n_in << 1;
                q_reg[k] <= {q_in[NB-2:0], ge};
                d_reg[k] <= d_in;
            end
        end
    end

    // Negate and clip the quotient to the most negative value.
    assign clip = q_reg[NB-1] > LIM;
    assign mag  = clip ? LIM[W-1:0] : q_reg[NB-1][W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            q_out_reg <= W'(0) - mag;
            sat_reg   <= clip;
        end
    end

    assign q   = q_out_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// File: rtl/core/llg_magnetization_derivative_unit.sv
// Top level of the Landau-Lifshitz-Gilbert derivative pipeline.
// Depends on llgmd_pkg, llgmd_delay, llgmd_qmul and llgmd_div.
`default_nettype none

// The unit takes one mesh node per item (magnetization and effective field
// in signed fixed point, damping unsigned, all with FRAC_BITS fraction bits)
// and returns dm/dt for that node, clipped to 32 bits, with a flag on tuser
// that is set when any intermediate or output value was saturated. One item
// is accepted every clock cycle while the pipeline is not holding; most of
// the pipeline is the restoring divider for -gamma/(1+alpha^2) that resolves
// one quotient bit per stage. When the result register is full and not
// taken, the whole pipeline holds. Configuration must be written on its own
// port only while no item is in flight; the block itself does not enforce
// this.
module llg_magnetization_derivative_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // Input item.
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: mag_x, mag_y, mag_z, field_x, field_y, field_z
    // (32 bits each), damping (31 bits), one pad bit.
    input  wire [223:0]                      s_tdata,
    // Result item.
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // Fields from bit 0: rate_x, rate_y, rate_z (32 bits each).
    output logic [95:0]                      m_tdata,
    // Fields from bit 0: saturated.
    output logic                             m_tuser,
    // Configuration writes.
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [llgmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [31:0]                       cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int WX  = ((W > 32) ? W : 32) + 1;
    localparam int NB  = W - 1 + F;
    localparam int DL  = NB + 5;
    localparam int LAT = DL + 10;

    localparam logic [W-1:0] MAXV  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINV  = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE_Q = W'(1) << F;

    // Saturate a sum that has grown by one bit.
    function automatic logic [W:0] sat_w(input logic [W:0] s);
        if (s[W] != s[W-1]) begin
            return {1'b1, s[W] ? MINV : MAXV};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        return sat_w(s);
    endfunction

    // Subtracting the most negative value always raises the flag.
    function automatic logic [W:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        logic [W:0] r;
        s = {a[W-1], a} - {b[W-1], b};
        r = sat_w(s);
        r[W] = r[W] | (b == MINV);
        return r;
    endfunction

    // Clip a 32-bit signed value into the datapath width.
    function automatic logic [W:0] clamp_in(input logic [31:0] v);
        logic signed [WX-1:0] x;
        logic signed [WX-1:0] hi;
        logic signed [WX-1:0] lo;
        x  = WX'(signed'(v));
        hi = {{(WX-W){1'b0}}, MAXV};
        lo = ~hi;
        if (x > hi) begin
            return {1'b1, MAXV};
        end
        if (x < lo) begin
            return {1'b1, MINV};
        end
        return {1'b0, x[W-1:0]};
    endfunction

    // Clip a datapath value to the 32-bit output.
    function automatic logic [32:0] clamp_out(input logic [W-1:0] v);
        logic signed [WX-1:0] x;
        logic signed [WX-1:0] hi;
        logic signed [WX-1:0] lo;
        x  = WX'(signed'(v));
        hi = {{(WX-31){1'b0}}, {31{1'b1}}};
        lo = ~hi;
        if (x > hi) begin
            return {1'b1, hi[31:0]};
        end
        if (x < lo) begin
            return {1'b1, lo[31:0]};
        end
        return {1'b0, x[31:0]};
    endfunction

    llgmd_pkg::cfg_t       cfg_reg;
    llgmd_pkg::pipe_ctrl_t ctrl;
    logic                  vld_reg [1:LAT];

    logic [W:0]          gam_c;
    logic [W:0]          rel_c;
    logic [W:0]          al_c;
    logic [W:0]          m_c [3];
    logic [W:0]          h_c [3];

    logic signed [W-1:0] m1_reg [3];
    logic signed [W-1:0] h1_reg [3];
    logic signed [W-1:0] al1_reg;
    logic                f1_reg;
    logic [3*W-1:0]      m1_pk;

    logic signed [W-1:0] aa3;
    logic                faa3;
    logic signed [W-1:0] mha3 [3];
    logic signed [W-1:0] mhb3 [3];
    logic signed [W-1:0] sq3 [3];
    logic [2:0]          mhfa;
    logic [2:0]          mhfb;
    logic [2:0]          sqf;
    logic                f1_d3;

    logic [W:0]          den_s;
    logic [W:0]          c_s [3];
    logic [2:0]          cfl;
    logic signed [W-1:0] den4_reg;
    logic [3*W-1:0]      c4_reg;
    logic                fa4_reg;

    logic [W:0]          s_s;
    logic [W:0]          mm_s;
    logic [W:0]          om_s;
    logic signed [W-1:0] s4_reg;
    logic signed [W-1:0] sq2_4_reg;
    logic                fm4_reg;
    logic signed [W-1:0] mm5_reg;
    logic                fm5_reg;
    logic signed [W-1:0] om6_reg;
    logic                fm6_reg;
    logic signed [W-1:0] k8;
    logic                fk8;
    logic                fm6_d8;
    logic [3*W-1:0]      m_d8;
    logic [3*W-1:0]      km10;
    logic [2:0]          fkm;
    logic                fm8_d10;
    logic [3*W-1:0]      km_d;
    logic                fm_d;

    logic signed [W-1:0] a1;
    logic                fdiv;
    logic [3*W-1:0]      c_dl;
    logic                fa_dl;
    logic [3*W-1:0]      m_dp;
    logic signed [W-1:0] al_d;
    logic [3*W-1:0]      p2;
    logic [2:0]          pfl;
    logic                fl_d2;
    logic signed [W-1:0] mpa [3];
    logic signed [W-1:0] mpb [3];
    logic [2:0]          mpfa;
    logic [2:0]          mpfb;
    logic                fp_d4;
    logic [W:0]          x_s [3];
    logic [2:0]          xfl;
    logic [3*W-1:0]      x5_reg;
    logic                fx5_reg;
    logic signed [W-1:0] d7 [3];
    logic [2:0]          dfl;
    logic                fx5_d7;
    logic [3*W-1:0]      p_d7;
    logic [W:0]          r8_s [3];
    logic [2:0]          r8fl;
    logic signed [W-1:0] r8_reg [3];
    logic                fr8_reg;
    logic [W:0]          r9_s [3];
    logic [2:0]          r9fl;
    logic signed [W-1:0] r9_reg [3];
    logic                fr9_reg;
    logic [32:0]         o_s [3];
    logic [95:0]         m_tdata_reg;
    logic                m_tuser_reg;

    // Configuration registers; the port never back-pressures.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gyro_ratio    <= 31'd65536;
            cfg_reg.precession_on <= 1'b1;
            cfg_reg.relax_rate    <= 31'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                llgmd_pkg::CFG_GYRO_RATIO:    cfg_reg.gyro_ratio    <= cfg_data[30:0];
                llgmd_pkg::CFG_PRECESSION_ON: cfg_reg.precession_on <= cfg_data[0];
                llgmd_pkg::CFG_RELAX_RATE:    cfg_reg.relax_rate    <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances unless a finished result is waiting.
    assign ctrl.en  = !m_tvalid || m_tready;
    assign s_tready = ctrl.en;

    // Valid bits travelling alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= LAT; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (ctrl.en) begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= LAT; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Input clipping into the datapath width.
    assign gam_c = clamp_in({1'b0, cfg_reg.gyro_ratio});
    assign rel_c = clamp_in({1'b0, cfg_reg.relax_rate});
    assign al_c  = clamp_in({1'b0, s_tdata[222:192]});

    for (genvar i = 0; i < 3; i++) begin : g_in
        assign m_c[i] = clamp_in(s_tdata[32*i +: 32]);
        assign h_c[i] = clamp_in(s_tdata[32*(i+3) +: 32]);
        assign m1_pk[W*i +: W] = m1_reg[i];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            for (int i = 0; i < 3; i++) begin
                m1_reg[i] <= m_c[i][W-1:0];
                h1_reg[i] <= h_c[i][W-1:0];
            end
            al1_reg <= al_c[W-1:0];
            f1_reg  <= m_c[0][W] | m_c[1][W] | m_c[2][W] | h_c[0][W] | h_c[1][W]
                     | h_c[2][W] | al_c[W] | gam_c[W] | rel_c[W];
        end
    end

    // First products: alpha squared, the two halves of m x h, and m_i squared.
    llgmd_qmul #(.W(W), .F(F)) u_aa (
        .aclk(aclk), .ctrl(ctrl), .a(al1_reg), .b(al1_reg), .p(aa3), .sat(faa3)
    );

    for (genvar i = 0; i < 3; i++) begin : g_mh
        localparam int J = (i + 1) % 3;
        localparam int L = (i + 2) % 3;
        llgmd_qmul #(.W(W), .F(F)) u_mha (
            .aclk(aclk), .ctrl(ctrl), .a(m1_reg[J]), .b(h1_reg[L]),
            .p(mha3[i]), .sat(mhfa[i])
        );
        llgmd_qmul #(.W(W), .F(F)) u_mhb (
            .aclk(aclk), .ctrl(ctrl), .a(m1_reg[L]), .b(h1_reg[J]),
            .p(mhb3[i]), .sat(mhfb[i])
        );
        llgmd_qmul #(.W(W), .F(F)) u_sq (
            .aclk(aclk), .ctrl(ctrl), .a(m1_reg[i]), .b(m1_reg[i]),
            .p(sq3[i]), .sat(sqf[i])
        );
        assign c_s[i] = sat_sub(mha3[i], mhb3[i]);
        assign cfl[i] = c_s[i][W];
    end

    llgmd_delay #(.WIDTH(1), .DEPTH(2)) u_f1_dly (
        .aclk(aclk), .ctrl(ctrl), .d(f1_reg), .q(f1_d3)
    );

    // Denominator 1 + alpha^2 and the cross product m x h.
    assign den_s = sat_add(ONE_Q, aa3);
    assign s_s   = sat_add(sq3[0], sq3[1]);

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            den4_reg  <= den_s[W-1:0];
            for (int i = 0; i < 3; i++) begin
                c4_reg[W*i +: W] <= c_s[i][W-1:0];
            end
            fa4_reg   <= f1_d3 | faa3 | den_s[W] | (|mhfa) | (|mhfb) | (|cfl);
            s4_reg    <= s_s[W-1:0];
            sq2_4_reg <= sq3[2];
            fm4_reg   <= (|sqf) | s_s[W];
        end
    end

    // Norm relaxation: |m|^2, then 1 - |m|^2.
    assign mm_s = sat_add(s4_reg, sq2_4_reg);
    assign om_s = sat_sub(ONE_Q, mm5_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            mm5_reg <= mm_s[W-1:0];
            fm5_reg <= fm4_reg | mm_s[W];
            om6_reg <= om_s[W-1:0];
            fm6_reg <= fm5_reg | om_s[W];
        end
    end

    llgmd_qmul #(.W(W), .F(F)) u_k (
        .aclk(aclk), .ctrl(ctrl), .a(rel_c[W-1:0]), .b(om6_reg), .p(k8), .sat(fk8)
    );

    llgmd_delay #(.WIDTH(1), .DEPTH(2)) u_fm6_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fm6_reg), .q(fm6_d8)
    );

    llgmd_delay #(.WIDTH(3*W), .DEPTH(7)) u_m8_dly (
        .aclk(aclk), .ctrl(ctrl), .d(m1_pk), .q(m_d8)
    );

    for (genvar i = 0; i < 3; i++) begin : g_km
        llgmd_qmul #(.W(W), .F(F)) u_km (
            .aclk(aclk), .ctrl(ctrl), .a(k8), .b(m_d8[W*i +: W]),
            .p(km10[W*i +: W]), .sat(fkm[i])
        );
    end

    llgmd_delay #(.WIDTH(1), .DEPTH(2)) u_fm8_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fm6_d8 | fk8), .q(fm8_d10)
    );

    llgmd_delay #(.WIDTH(3*W), .DEPTH(DL-2)) u_km_dly (
        .aclk(aclk), .ctrl(ctrl), .d(km10), .q(km_d)
    );

    llgmd_delay #(.WIDTH(1), .DEPTH(DL-2)) u_fm_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fm8_d10 | (|fkm)), .q(fm_d)
    );

    // a1 = -gamma / (1 + alpha^2).
    llgmd_div #(.W(W), .F(F)) u_div (
        .aclk(aclk), .ctrl(ctrl), .g(gam_c[W-2:0]), .d(den4_reg[W-2:0]),
        .q(a1), .sat(fdiv)
    );

    llgmd_delay #(.WIDTH(3*W), .DEPTH(DL-4)) u_c_dly (
        .aclk(aclk), .ctrl(ctrl), .d(c4_reg), .q(c_dl)
    );

    llgmd_delay #(.WIDTH(1), .DEPTH(DL-4)) u_fa_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fa4_reg), .q(fa_dl)
    );

    llgmd_delay #(.WIDTH(3*W), .DEPTH(DL+1)) u_mp_dly (
        .aclk(aclk), .ctrl(ctrl), .d(m1_pk), .q(m_dp)
    );

    llgmd_delay #(.WIDTH(W), .DEPTH(DL+4)) u_al_dly (
        .aclk(aclk), .ctrl(ctrl), .d(al1_reg), .q(al_d)
    );

    // Precession term p = a1 * (m x h).
    for (genvar i = 0; i < 3; i++) begin : g_p
        llgmd_qmul #(.W(W), .F(F)) u_p (
            .aclk(aclk), .ctrl(ctrl), .a(a1), .b(c_dl[W*i +: W]),
            .p(p2[W*i +: W]), .sat(pfl[i])
        );
    end

    llgmd_delay #(.WIDTH(1), .DEPTH(2)) u_fl_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fa_dl | fdiv), .q(fl_d2)
    );

    // Damping cross product m x p.
    for (genvar i = 0; i < 3; i++) begin : g_mp
        localparam int J = (i + 1) % 3;
        localparam int L = (i + 2) % 3;
        llgmd_qmul #(.W(W), .F(F)) u_mpa (
            .aclk(aclk), .ctrl(ctrl), .a(m_dp[W*J +: W]), .b(p2[W*L +: W]),
            .p(mpa[i]), .sat(mpfa[i])
        );
        llgmd_qmul #(.W(W), .F(F)) u_mpb (
            .aclk(aclk), .ctrl(ctrl), .a(m_dp[W*L +: W]), .b(p2[W*J +: W]),
            .p(mpb[i]), .sat(mpfb[i])
        );
        assign x_s[i] = sat_sub(mpa[i], mpb[i]);
        assign xfl[i] = x_s[i][W];
    end

    llgmd_delay #(.WIDTH(1), .DEPTH(2)) u_fp_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fl_d2 | (|pfl)), .q(fp_d4)
    );

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            for (int i = 0; i < 3; i++) begin
                x5_reg[W*i +: W] <= x_s[i][W-1:0];
            end
            fx5_reg <= fp_d4 | (|mpfa) | (|mpfb) | (|xfl);
        end
    end

    // Damping term d = alpha * (m x p).
    for (genvar i = 0; i < 3; i++) begin : g_d
        llgmd_qmul #(.W(W), .F(F)) u_d (
            .aclk(aclk), .ctrl(ctrl), .a(al_d), .b(x5_reg[W*i +: W]),
            .p(d7[i]), .sat(dfl[i])
        );
    end

    llgmd_delay #(.WIDTH(1), .DEPTH(2)) u_fx_dly (
        .aclk(aclk), .ctrl(ctrl), .d(fx5_reg), .q(fx5_d7)
    );

    llgmd_delay #(.WIDTH(3*W), .DEPTH(5)) u_p_dly (
        .aclk(aclk), .ctrl(ctrl), .d(p2), .q(p_d7)
    );

    // Sum of precession (if precession_on is set) and damping, then the relaxation term, then output clip.
    for (genvar i = 0; i < 3; i++) begin : g_sum
        assign r8_s[i] = cfg_reg.precession_on ? sat_add(p_d7[W*i +: W], d7[i])
                                               : {1'b0, d7[i]};
        assign r8fl[i] = r8_s[i][W];
        assign r9_s[i] = sat_add(r8_reg[i], km_d[W*i +: W]);
        assign r9fl[i] = r9_s[i][W];
        assign o_s[i]  = clamp_out(r9_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            for (int i = 0; i < 3; i++) begin
                r8_reg[i] <= r8_s[i][W-1:0];
                r9_reg[i] <= r9_s[i][W-1:0];
                m_tdata_reg[32*i +: 32] <= o_s[i][31:0];
            end
            fr8_reg     <= fx5_d7 | (|dfl) | (|r8fl);
            fr9_reg     <= fr8_reg | fm_d | (|r9fl);
            m_tuser_reg <= fr9_reg | o_s[0][32] | o_s[1][32] | o_s[2][32];
        end
    end

    assign m_tvalid = vld_reg[LAT];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The coefficient a1 is never positive.
    a_a1_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[DL] |-> (a1[W-1] || (a1 == '0)))
        else $error("a1 coefficient is positive");

    // Without precession the sum stage passes the damping term unchanged.
    a_no_prec: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[DL+7] && ctrl.en && !cfg_reg.precession_on)
            |=> (r8_reg[0] == $past(d7[0])))
        else $error("damping-only path altered the damping term");

    // Reset empties the result register.
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid directly after reset");

endmodule

`default_nettype wire
